### sv/filename_glob_filter_top_defines.svh
// assertion macros for the filename glob filter
`ifndef FILENAME_GLOB_FILTER_TOP_DEFINES_SVH
`define FILENAME_GLOB_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define FGF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("filename glob filter check failed")

`define FGF_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("filename glob filter forbidden condition")

`else

`define FGF_ASSERT(label, prop)

`define FGF_ASSERT_NEVER(label, cond)

`endif

`endif

### sv/fgf_pkg.sv
// shared constants and helpers for the filename glob filter
package fgf_pkg;

    localparam int DEFAULT_PATTERN_BYTES = 16;
    localparam int TEXT_BYTES            = 16;
    localparam int CFG_DATA_W            = 64;
    localparam int CFG_INDEX_W           = 3;
    localparam int LEN_CFG_W             = 5;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_TEXT_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_TEXT_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_TEXT_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_TEXT_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLD_LENGTH    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLES = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_WANTED    = 3'd7;

    localparam int EN_NAME = 0;
    localparam int EN_FOLD = 1;
    localparam int EN_TYPE = 2;

    localparam logic TYPE_WANT_FILE = 1'b0;
    localparam logic TYPE_WANT_DIR  = 1'b1;

    // maps A-Z to a-z when folding, leaves every other byte alone
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
        logic [7:0] r;
        r = c;
        if (fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

### sv/filename_glob_filter_top.sv
// filename glob filter: top level
//
// Path bytes enter on the s_ stream, one byte per transaction; s_tlast marks
// the last byte of a path and s_tuser carries the entry kind with it. A '/'
// byte restarts the filename. For every path one result transaction leaves on
// the m_ stream with the selected flag in bit 0 of m_tdata; bytes that are not
// the last of a path give no result.
// Patterns, lengths, enables and the wanted type are written over the cfg_
// port (index, data, write enable), by the user only while no path is in
// flight; the block does not enforce this. A byte is held in the input
// register, and the result of a last byte is registered in the output
// register. One byte is taken every cycle unless a last byte waits on a held
// output register; the rate is set by the single input register stage,
// whose parallel window compares and prefix check are combinational.
// Reset clears the configuration to zero, empties both stages and clears the
// name state. When the receiver stalls, the result holds in the output
// register; the next bytes that cause no result still flow, and a further last
// byte waits in the input register until the output register is taken.
module filename_glob_filter_top #(
    parameter int PATTERN_BYTES = fgf_pkg::DEFAULT_PATTERN_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] path_char
    input  logic                             s_tlast,   // path_end
    input  logic [1:0]                       s_tuser,   // [1:0] entry_kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [0] selected, [7:1] zero
    input  logic                             cfg_we,
    input  logic [fgf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fgf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fgf_pkg::*;

`include "filename_glob_filter_top_defines.svh"

    localparam int WIN_W  = PATTERN_BYTES * 8;
    localparam int LEN_W  = $clog2(PATTERN_BYTES + 1);
    localparam int SEEN_W = $clog2(PATTERN_BYTES + 2);
    localparam int IDX_W  = $clog2(PATTERN_BYTES);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(PATTERN_BYTES + 1);

    // configuration
    logic [63:0]          name_lo_reg, name_hi_reg, fold_lo_reg, fold_hi_reg;
    logic [LEN_CFG_W-1:0] name_len_cfg_reg, fold_len_cfg_reg;
    logic [2:0]           enables_reg;
    logic                 type_wanted_reg;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic [1:0] s1_kind_reg;

    // name state
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [1:0]        hit_reg, hit_next;     // [0] exact, [1] folded
    logic [1:0]        good_reg, good_next;

    // output stage
    logic m_valid_reg, m_valid_next;
    logic m_sel_reg, m_sel_next;

    logic s_accept, advance, out_load;
    logic [8*TEXT_BYTES-1:0] name_text, fold_text;
    logic [WIN_W-1:0] pat_name, pat_fold;
    logic [LEN_W-1:0] len_name, len_fold;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] l);
        logic [LEN_W-1:0] r;
        if (int'(l) > PATTERN_BYTES)
        begin
            r = LEN_W'(PATTERN_BYTES);
        end
        else
        begin
            r = LEN_W'(l);
        end
        return r;
    endfunction

    // newest n window bytes against pattern bytes off .. off+n-1
    function automatic logic win_equal(input logic [WIN_W-1:0] win,
                                       input logic [WIN_W-1:0] pat,
                                       input logic fold, input int off, input int n);
        logic eq;
        int   idx;
        eq = 1'b1;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            idx = off + n - 1 - k;
            if (k < n && idx >= 0 && idx < PATTERN_BYTES)
            begin
                if (fold_byte(pat[8*idx +: 8], fold) != fold_byte(win[8*k +: 8], fold))
                begin
                    eq = 1'b0;
                end
            end
        end
        if (n > PATTERN_BYTES)
        begin
            eq = 1'b0;
        end
        return eq;
    endfunction

    function automatic logic glob_pass(input logic [WIN_W-1:0] win,
                                       input logic [WIN_W-1:0] pat,
                                       input logic fold, input logic [LEN_W-1:0] len,
                                       input logic [SEEN_W-1:0] seen,
                                       input logic hit, input logic good);
        logic       r;
        logic [7:0] first, last;
        int         n;
        n     = int'(len);
        first = pat[7:0];
        last  = (n > 0) ? pat[8*(n-1) +: 8] : 8'd0;
        if (n == 0)
        begin
            r = 1'b1;
        end
        else if (n == 1 && first == CHAR_STAR)
        begin
            r = 1'b1;
        end
        else if (first == CHAR_STAR && last == CHAR_STAR)
        begin
            // empty inner part: folded filter still wants a non-empty name
            if (n == 2)
            begin
                r = fold ? (seen != '0) : 1'b1;
            end
            else
            begin
                r = hit;
            end
        end
        else if (first == CHAR_STAR)
        begin
            r = (int'(seen) >= n - 1) && win_equal(win, pat, fold, 1, n - 1);
        end
        else if (last == CHAR_STAR)
        begin
            r = (int'(seen) >= n - 1) && good;
        end
        else
        begin
            r = (int'(seen) == n) && win_equal(win, pat, fold, 0, n);
        end
        return r;
    endfunction

    assign name_text = {name_hi_reg, name_lo_reg};
    assign fold_text = {fold_hi_reg, fold_lo_reg};

    // pattern bytes past the register text read as zero
    always_comb
    begin
        pat_name = '0;
        pat_fold = '0;
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            if (i < TEXT_BYTES)
            begin
                pat_name[8*i +: 8] = name_text[8*(i % TEXT_BYTES) +: 8];
                pat_fold[8*i +: 8] = fold_text[8*(i % TEXT_BYTES) +: 8];
            end
        end
    end

    assign len_name = clamp_len(name_len_cfg_reg);
    assign len_fold = clamp_len(fold_len_cfg_reg);

    assign advance  = s1_valid_reg && (!s1_last_reg || !m_valid_reg || m_tready);
    assign out_load = advance && s1_last_reg;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        logic              slash;
        logic [WIN_W-1:0]  win_post;
        logic [SEEN_W-1:0] seen_post;
        logic [1:0]        hit_post, good_post;
        logic [LEN_W-1:0]  len_f;
        logic [WIN_W-1:0]  pat_f;
        logic              sel;
        int                pos;

        slash = (s1_char_reg == CHAR_SLASH);
        pos   = int'(seen_reg);
        len_f = len_name;
        pat_f = pat_name;
        if (slash)
        begin
            win_post  = '0;
            seen_post = '0;
            hit_post  = 2'b00;
            good_post = 2'b11;
        end
        else
        begin
            win_post  = {win_reg[WIN_W-9:0], s1_char_reg};
            seen_post = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 1'b1;
            hit_post  = hit_reg;
            good_post = good_reg;
            for (int f = 0; f < 2; f++)
            begin
                len_f = (f == 1) ? len_fold : len_name;
                pat_f = (f == 1) ? pat_fold : pat_name;
                if (len_f != '0 && pos < int'(len_f) - 1)
                begin
                    if (fold_byte(pat_f[8*seen_reg[IDX_W-1:0] +: 8], f == 1)
                        != fold_byte(s1_char_reg, f == 1))
                    begin
                        good_post[f] = 1'b0;
                    end
                end
                if (int'(len_f) >= 3 && int'(seen_post) >= int'(len_f) - 2
                    && win_equal(win_post, pat_f, f == 1, 1, int'(len_f) - 2))
                begin
                    hit_post[f] = 1'b1;
                end
            end
        end

        sel = 1'b1;
        if (enables_reg[EN_TYPE])
        begin
            if (type_wanted_reg == TYPE_WANT_FILE && s1_kind_reg != KIND_FILE)
            begin
                sel = 1'b0;
            end
            if (type_wanted_reg == TYPE_WANT_DIR && s1_kind_reg != KIND_DIR)
            begin
                sel = 1'b0;
            end
        end
        if (enables_reg[EN_NAME] && !glob_pass(win_post, pat_name, 1'b0, len_name,
                                               seen_post, hit_post[0], good_post[0]))
        begin
            sel = 1'b0;
        end
        if (enables_reg[EN_FOLD] && !glob_pass(win_post, pat_fold, 1'b1, len_fold,
                                               seen_post, hit_post[1], good_post[1]))
        begin
            sel = 1'b0;
        end

        win_next  = win_reg;
        seen_next = seen_reg;
        hit_next  = hit_reg;
        good_next = good_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                win_next  = '0;
                seen_next = '0;
                hit_next  = 2'b00;
                good_next = 2'b11;
            end
            else
            begin
                win_next  = win_post;
                seen_next = seen_post;
                hit_next  = hit_post;
                good_next = good_post;
            end
        end

        m_sel_next   = out_load ? sel : m_sel_reg;
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_lo_reg      <= '0;
            name_hi_reg      <= '0;
            fold_lo_reg      <= '0;
            fold_hi_reg      <= '0;
            name_len_cfg_reg <= '0;
            fold_len_cfg_reg <= '0;
            enables_reg      <= '0;
            type_wanted_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NAME_TEXT_LOW:  name_lo_reg      <= cfg_data;
                REG_NAME_TEXT_HIGH: name_hi_reg      <= cfg_data;
                REG_FOLD_TEXT_LOW:  fold_lo_reg      <= cfg_data;
                REG_FOLD_TEXT_HIGH: fold_hi_reg      <= cfg_data;
                REG_NAME_LENGTH:    name_len_cfg_reg <= cfg_data[LEN_CFG_W-1:0];
                REG_FOLD_LENGTH:    fold_len_cfg_reg <= cfg_data[LEN_CFG_W-1:0];
                REG_FILTER_ENABLES: enables_reg      <= cfg_data[2:0];
                REG_TYPE_WANTED:    type_wanted_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
            seen_reg     <= '0;
            hit_reg      <= 2'b00;
            good_reg     <= 2'b11;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            win_reg     <= win_next;
            seen_reg    <= seen_next;
            hit_reg     <= hit_next;
            good_reg    <= good_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // input payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
            s1_kind_reg <= s_tuser;
        end
        m_sel_reg <= m_sel_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_sel_reg};

    `FGF_ASSERT(a_load_needs_last, out_load |-> s1_valid_reg && s1_last_reg);
    `FGF_ASSERT(a_held_byte_waits,
                s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_char_reg));
    `FGF_ASSERT_NEVER(a_seen_range, seen_reg > SEEN_MAX);
    `FGF_ASSERT(a_last_clears_name, advance && s1_last_reg |=> seen_reg == '0 && good_reg == 2'b11);
    `FGF_ASSERT_NEVER(a_ready_when_stuck, s_tready && s1_valid_reg && !advance);

endmodule

### bench/testbench.sv
// self-checking testbench for the filename glob filter top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fgf_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int WINDOW       = DEFAULT_PATTERN_BYTES;

    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef enum int {
        GLOB_EMPTY,
        GLOB_STAR,
        GLOB_DOUBLE_STAR,
        GLOB_CONTAINS,
        GLOB_SUFFIX,
        GLOB_PREFIX,
        GLOB_EXACT
    } glob_form_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   s_tlast = 1'b0;
    logic [1:0]             s_tuser = 2'd0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // register copies used for prediction
    logic [63:0] name_lo = '0;
    logic [63:0] name_hi = '0;
    logic [63:0] fold_lo = '0;
    logic [63:0] fold_hi = '0;
    logic [4:0]  len_reg [2] = '{5'd0, 5'd0};
    logic [2:0]  enables_reg = '0;
    logic        want_reg = 1'b0;

    // filename state, index 0 of the window is the newest byte
    logic [7:0]  name_window [WINDOW];
    int unsigned name_seen = 0;
    bit          contains_hit [2] = '{1'b0, 1'b0};
    bit          prefix_good [2] = '{1'b1, 1'b1};

    bit          expected_selected [$];

    // stimulus helpers
    logic [127:0] core_bits [2];
    int unsigned  core_len [2] = '{0, 0};
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_cycles = 0;
    int           bytes_sent = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    filename_glob_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] case_fold(input logic [7:0] c, input bit fold);
        if (fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte(input bit fold, input int unsigned i);
        logic [127:0] text;
        text = fold ? {fold_hi, fold_lo} : {name_hi, name_lo};
        if (i >= 16)
            return 8'h00;
        return text[8*i +: 8];
    endfunction

    function automatic int unsigned pattern_length(input bit fold);
        int unsigned n;
        n = len_reg[fold];
        return (n > WINDOW) ? WINDOW : n;
    endfunction

    // newest n name bytes against pattern bytes off .. off+n-1
    function automatic bit tail_matches(input bit fold, input int unsigned off,
                                        input int unsigned n);
        if (n > WINDOW)
            return 1'b0;
        for (int unsigned j = 0; j < n; j++)
        begin
            if (case_fold(pattern_byte(fold, off + j), fold) !=
                case_fold(name_window[n - 1 - j], fold))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void track_name_byte(input bit fold, input logic [7:0] c,
                                            input int unsigned pos, input int unsigned seen);
        int unsigned len;
        len = pattern_length(fold);
        if (len >= 1 && pos < len - 1 &&
            case_fold(pattern_byte(fold, pos), fold) != case_fold(c, fold))
            prefix_good[fold] = 1'b0;
        if (len >= 3 && seen >= len - 2 && tail_matches(fold, 1, len - 2))
            contains_hit[fold] = 1'b1;
    endfunction

    function automatic bit glob_accepts(input bit fold);
        int unsigned len;
        logic [7:0]  head;
        logic [7:0]  tail;
        len = pattern_length(fold);
        if (len == 0)
            return 1'b1;
        head = pattern_byte(fold, 0);
        tail = pattern_byte(fold, len - 1);
        if (len == 1 && head == CHAR_STAR)
            return 1'b1;
        if (head == CHAR_STAR && tail == CHAR_STAR)
        begin
            // a bare double star only rejects an empty name when folding
            if (len == 2)
                return fold ? (name_seen > 0) : 1'b1;
            return contains_hit[fold];
        end
        if (head == CHAR_STAR)
            return name_seen >= len - 1 && tail_matches(fold, 1, len - 1);
        if (tail == CHAR_STAR)
            return name_seen >= len - 1 && prefix_good[fold];
        return name_seen == len && tail_matches(fold, 0, len);
    endfunction

    function automatic void clear_name();
        for (int i = 0; i < WINDOW; i++)
            name_window[i] = 8'h00;
        name_seen = 0;
        contains_hit = '{1'b0, 1'b0};
        prefix_good = '{1'b1, 1'b1};
    endfunction

    function automatic void predict_selected(input logic [7:0] c, input bit last,
                                             input logic [1:0] kind);
        int unsigned pos;
        int unsigned seen;
        bit          pass;
        pass = 1'b1;
        if (c == CHAR_SLASH)
            clear_name();
        else
        begin
            pos = name_seen;
            seen = (pos + 1 > WINDOW + 1) ? WINDOW + 1 : pos + 1;
            for (int i = WINDOW - 1; i > 0; i--)
                name_window[i] = name_window[i - 1];
            name_window[0] = c;
            track_name_byte(1'b0, c, pos, seen);
            track_name_byte(1'b1, c, pos, seen);
            name_seen = seen;
        end
        if (!last)
            return;
        if (enables_reg[EN_TYPE])
        begin
            if (want_reg == TYPE_WANT_FILE && kind != KIND_FILE)
                pass = 1'b0;
            if (want_reg == TYPE_WANT_DIR && kind != KIND_DIR)
                pass = 1'b0;
        end
        if (enables_reg[EN_NAME] && !glob_accepts(1'b0))
            pass = 1'b0;
        if (enables_reg[EN_FOLD] && !glob_accepts(1'b1))
            pass = 1'b0;
        clear_name();
        expected_selected.push_back(pass);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void note_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s, expected m_tdata=%02h, got %02h",
                     $realtime, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_selected.size() == 0)
                note_mismatch("result with no path pending", 8'h00, m_tdata);
            else
            begin
                want = expected_selected.pop_front();
                if (m_tdata !== {7'd0, want})
                    note_mismatch("selected flag", {7'd0, want}, m_tdata);
            end
        end
    end

    // receiver, with an optional long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_NAME_TEXT_LOW:  name_lo = value;
            REG_NAME_TEXT_HIGH: name_hi = value;
            REG_FOLD_TEXT_LOW:  fold_lo = value;
            REG_FOLD_TEXT_HIGH: fold_hi = value;
            REG_NAME_LENGTH:    len_reg[0] = value[4:0];
            REG_FOLD_LENGTH:    len_reg[1] = value[4:0];
            REG_FILTER_ENABLES: enables_reg = value[2:0];
            REG_TYPE_WANTED:    want_reg = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] c, input bit last, input logic [1:0] kind);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_selected(c, last, kind);
        bytes_sent++;
    endtask

    task automatic send_path(input logic [7:0] path_q[$], input logic [1:0] kind);
        for (int i = 0; i < path_q.size(); i++)
        begin
            if (i == path_q.size() - 1)
                send_byte(path_q[i], 1'b1, kind);
            else
                send_byte(path_q[i], 1'b0, 2'($urandom_range(3)));
        end
    endtask

    task automatic send_text(input string s, input logic [1:0] kind);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1, kind);
    endtask

    // also lets a byte still in the input stage settle before config changes
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_selected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_pattern(input bit fold, input string s, input logic [4:0] len);
        logic [127:0] text;
        text = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            text[8*i +: 8] = s[i];
        write_reg(fold ? REG_FOLD_TEXT_LOW : REG_NAME_TEXT_LOW, text[63:0]);
        write_reg(fold ? REG_FOLD_TEXT_HIGH : REG_NAME_TEXT_HIGH, text[127:64]);
        write_reg(fold ? REG_FOLD_LENGTH : REG_NAME_LENGTH, 64'(len));
    endtask

    // ---------------------------------------------------------------- random content

    function automatic logic [7:0] random_char();
        string common;
        common = "abAB.*";
        if ($urandom_range(7) == 0)
            return 8'($urandom_range(255));
        return common[$urandom_range(common.len() - 1)];
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_UPPER_A + CASE_OFFSET && c <= CHAR_UPPER_Z + CASE_OFFSET);
    endfunction

    task automatic randomize_glob(input bit fold);
        glob_form_e   form;
        int unsigned  room;
        int unsigned  n;
        int unsigned  off;
        int unsigned  total;
        logic [127:0] text;
        logic [63:0]  len_word;
        form = glob_form_e'($urandom_range(6));
        text = {$urandom, $urandom, $urandom, $urandom};
        room = (form == GLOB_CONTAINS) ? 14 :
               (form == GLOB_SUFFIX || form == GLOB_PREFIX) ? 15 : 16;
        n = ($urandom_range(7) == 0) ? room : $urandom_range(1, 4);
        off = (form == GLOB_CONTAINS || form == GLOB_SUFFIX) ? 1 : 0;
        core_bits[fold] = '0;
        core_len[fold] = 0;
        total = 0;
        case (form)
            GLOB_EMPTY: total = 0;
            GLOB_STAR:
            begin
                text[7:0] = CHAR_STAR;
                total = 1;
            end
            GLOB_DOUBLE_STAR:
            begin
                text[15:0] = {CHAR_STAR, CHAR_STAR};
                total = 2;
            end
            default:
            begin
                core_len[fold] = n;
                for (int i = 0; i < n; i++)
                begin
                    core_bits[fold][8*i +: 8] = random_char();
                    text[8*(off + i) +: 8] = core_bits[fold][8*i +: 8];
                end
                total = n + ((form == GLOB_CONTAINS) ? 2 : (form == GLOB_EXACT) ? 0 : 1);
                if (off == 1)
                    text[7:0] = CHAR_STAR;
                if (form == GLOB_CONTAINS || form == GLOB_PREFIX)
                    text[8*(total - 1) +: 8] = CHAR_STAR;
            end
        endcase
        len_word = {$urandom, $urandom};
        len_word[4:0] = 5'(total);
        // full-length patterns sometimes carry an oversized length
        if (total == 16 && $urandom_range(1) == 0)
            len_word[4:0] = 5'($urandom_range(16, 31));
        if ($urandom_range(9) == 0)
        begin
            text = {$urandom, $urandom, $urandom, $urandom};
            len_word[4:0] = 5'($urandom_range(31));
        end
        write_reg(fold ? REG_FOLD_TEXT_LOW : REG_NAME_TEXT_LOW, text[63:0]);
        write_reg(fold ? REG_FOLD_TEXT_HIGH : REG_NAME_TEXT_HIGH, text[127:64]);
        write_reg(fold ? REG_FOLD_LENGTH : REG_NAME_LENGTH, len_word);
    endtask

    // mostly names built around a pattern core, the rest noise
    function automatic void build_path(ref logic [7:0] path_q[$]);
        int unsigned style;
        int unsigned src;
        int unsigned n;
        logic [7:0]  c;
        path_q.delete();
        if ($urandom_range(2) == 0)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                path_q.push_back(random_char());
            path_q.push_back(CHAR_SLASH);
        end
        style = $urandom_range(9);
        if (style < 6)
        begin
            src = $urandom_range(1);
            n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                path_q.push_back(random_char());
            for (int i = 0; i < core_len[src]; i++)
            begin
                c = core_bits[src][8*i +: 8];
                if (is_letter(c) && $urandom_range(src ? 1 : 7) == 0)
                    c = c ^ CASE_OFFSET;
                path_q.push_back(c);
            end
            n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                path_q.push_back(random_char());
            if ($urandom_range(4) == 0 && path_q.size() != 0)
                path_q[$urandom_range(path_q.size() - 1)] = random_char();
        end
        else if (style < 9)
        begin
            n = $urandom_range(20);
            for (int i = 0; i < n; i++)
                path_q.push_back(random_char());
        end
        if (path_q.size() == 0 || style == 9)
            path_q.push_back(CHAR_SLASH);
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_text("a", KIND_OTHER);
        send_text("/", KIND_UNKNOWN);
    endtask

    task automatic test_type_filter();
        wait_idle();
        write_reg(REG_FILTER_ENABLES, 64'd1 << EN_TYPE);
        write_reg(REG_TYPE_WANTED, 64'(TYPE_WANT_FILE));
        send_text("f", KIND_OTHER);
        send_text("f", KIND_FILE);
        send_text("f", KIND_DIR);
        send_text("f", KIND_UNKNOWN);
        wait_idle();
        write_reg(REG_TYPE_WANTED, 64'(TYPE_WANT_DIR));
        send_text("d", KIND_FILE);
        send_text("d", KIND_DIR);
        send_text("d", KIND_UNKNOWN);
    endtask

    task automatic test_glob_modes();
        wait_idle();
        write_reg(REG_FILTER_ENABLES, 64'd1 << EN_NAME);
        // a star in the middle is an ordinary byte
        set_pattern(1'b0, "Ab*c", 5'd4);
        send_text("d/Ab*c", KIND_FILE);
        send_text("Ab*cd", KIND_FILE);
        wait_idle();
        set_pattern(1'b0, "ab*", 5'd3);
        send_text("abz", KIND_FILE);
        send_text("a", KIND_FILE);
        wait_idle();
        set_pattern(1'b0, "*.c", 5'd3);
        send_text("x.c", KIND_FILE);
        send_text("x.C", KIND_FILE);
        wait_idle();
        set_pattern(1'b0, "*b*", 5'd3);
        send_text("abc", KIND_FILE);
        wait_idle();
        set_pattern(1'b0, "**", 5'd2);
        send_text("/", KIND_FILE);
        wait_idle();
        write_reg(REG_FILTER_ENABLES, 64'd1 << EN_FOLD);
        set_pattern(1'b1, "**", 5'd2);
        send_text("/", KIND_FILE);
        send_text("a/", KIND_FILE);
        send_text("Q", KIND_FILE);
        wait_idle();
        set_pattern(1'b1, "READ.me", 5'd7);
        send_text("read.ME", KIND_FILE);
        wait_idle();
        set_pattern(1'b1, "*", 5'd1);
        send_byte(8'h00, 1'b0, KIND_OTHER);
        send_byte(8'hFF, 1'b1, KIND_FILE);
        // oversized length on an all-ones pattern, everything enabled
        wait_idle();
        set_pattern(1'b1, "", 5'd0);
        write_reg(REG_NAME_TEXT_LOW, '1);
        write_reg(REG_NAME_TEXT_HIGH, '1);
        write_reg(REG_NAME_LENGTH, 64'd31);
        write_reg(REG_FILTER_ENABLES, 64'd7);
        write_reg(REG_TYPE_WANTED, 64'(TYPE_WANT_DIR));
        for (int i = 0; i < 16; i++)
            send_byte(8'hFF, i == 15, KIND_DIR);
    endtask

    task automatic test_write_mid_path();
        wait_idle();
        write_reg(REG_FILTER_ENABLES, (64'd1 << EN_NAME) | (64'd1 << EN_FOLD));
        write_reg(REG_TYPE_WANTED, 64'(TYPE_WANT_FILE));
        set_pattern(1'b0, "xz*", 5'd3);
        set_pattern(1'b1, "*Bc*", 5'd4);
        send_byte("a", 1'b0, KIND_OTHER);
        send_byte("b", 1'b0, KIND_OTHER);
        wait_idle();
        // earlier bytes keep their old prefix and contains verdicts
        set_pattern(1'b0, "ab*", 5'd3);
        set_pattern(1'b1, "*c", 5'd2);
        send_byte("c", 1'b1, KIND_FILE);
    endtask

    task automatic test_random_paths();
        logic [7:0] path_q[$];
        int         start;
        repeat (5)
        begin
            wait_idle();
            randomize_glob(1'b0);
            randomize_glob(1'b1);
            write_reg(REG_FILTER_ENABLES, 64'($urandom_range(7)));
            write_reg(REG_TYPE_WANTED, 64'($urandom_range(1)));
            start = bytes_sent;
            while (bytes_sent - start < 22)
            begin
                build_path(path_q);
                send_path(path_q, 2'($urandom_range(3)));
            end
        end
    endtask

    task automatic test_output_stall();
        logic [7:0] path_q[$];
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 150;
        repeat (12)
        begin
            build_path(path_q);
            send_path(path_q, 2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        clear_name();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 64;
        test_reset_defaults();
        test_type_filter();
        test_glob_modes();
        test_write_mid_path();
        test_random_paths();

        wait_idle();
        send_idle_pct = 64;
        recv_idle_pct = 37;
        test_random_paths();

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_paths();

        test_output_stall();
        wait_idle();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
